### rtl/core/lrs_pkg.sv
// Shared types and constants for the LFU replacement store.
package lrs_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 5;
  localparam int SLOT_W          = 4;
  localparam int USE_W           = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit_hit;
    logic commit_insert;
    logic commit_evict;
    logic mask_init;
    logic mask_step;
  } lrs_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit_any;
    logic full;
    logic bit_last;
  } lrs_status_t;

endpackage

### rtl/core/lfu_replacement_store_core.sv
// Top level of the LFU replacement store: controller, datapath and config port.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    item_value
//   out      output     out_valid / out_ready  hit, slot, use_count, evicted, evicted_value
//   cfg      input      cfg_valid / cfg_ready  cfg_data (capacity)
//
// A hit, or a miss while the store has room, is registered on acceptance and committed
// from DECIDE. A miss on a full store first runs the bit-serial search for the lowest
// use count, which visits one count bit per cycle, and then commits from EVICT.
// Reset is one cycle of rst; no clearing pass, since only filled slots are read.
// The result sits in an output register, so a new transaction is accepted while a
// result waits; a later result holds its commit until that register is taken.
module lfu_replacement_store_core #(
  parameter int DEPTH       = lrs_pkg::DEPTH_DEF,
  parameter int COUNT_WIDTH = lrs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [lrs_pkg::VALUE_W-1:0] item_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic        [lrs_pkg::SLOT_W-1:0]  slot,
  output logic        [lrs_pkg::USE_W-1:0]   use_count,
  output logic                               evicted,
  output logic signed [lrs_pkg::VALUE_W-1:0] evicted_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [lrs_pkg::CAP_W-1:0]   cfg_data
);
  import lrs_pkg::*;

  lrs_cmd_t    cmd;
  lrs_status_t status;

  // The capacity register takes a write in any cycle; the user makes writes only while
  // no transaction is in flight, as the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  lrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the entry cells, whose parallel comparators find a hit
  // in the cycle the transaction is accepted.
  lrs_datapath #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .in_item       (item_value),
    .cmd           (cmd),
    .status        (status),
    .hit           (hit),
    .slot          (slot),
    .use_count     (use_count),
    .evicted       (evicted),
    .evicted_value (evicted_value)
  );

endmodule

### rtl/core/lrs_ctrl.sv
// Sequencing state machine of the LFU replacement store.
module lrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lrs_pkg::lrs_status_t status,
  output lrs_pkg::lrs_cmd_t    cmd
);
  import lrs_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DECIDE,
    MIN_STEP,
    EVICT
  } state_t;

  state_t state;
  logic   out_free;
  logic   commit;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;
  assign commit   = cmd.commit_hit || cmd.commit_insert || cmd.commit_evict;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      DECIDE: begin
        if (status.hit_any) begin
          cmd.commit_hit = out_free;
        end else if (!status.full) begin
          cmd.commit_insert = out_free;
        end else begin
          cmd.mask_init = 1'b1;
        end
      end
      MIN_STEP: begin
        cmd.mask_step = 1'b1;
      end
      EVICT: begin
        cmd.commit_evict = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (cmd.mask_init) begin
            state <= MIN_STEP;
          end else if (commit) begin
            state <= IDLE;
          end
        end
        MIN_STEP: begin
          if (status.bit_last) begin
            state <= EVICT;
          end
        end
        EVICT: begin
          if (commit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A result may only be written when the output register is free.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> out_free)
    else $error("result committed over a pending result");

  // Every commit presents a result in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed result not presented");

endmodule

### rtl/core/lrs_datapath.sv
// Entry cells, match logic, bit-serial minimum search and result register.
module lrs_datapath #(
  parameter int DEPTH       = lrs_pkg::DEPTH_DEF,
  parameter int COUNT_WIDTH = lrs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr,
  input  logic        [lrs_pkg::CAP_W-1:0]     cfg_data,
  input  logic signed [lrs_pkg::VALUE_W-1:0]   in_item,
  input  lrs_pkg::lrs_cmd_t                    cmd,
  output lrs_pkg::lrs_status_t                 status,
  output logic                                 hit,
  output logic        [lrs_pkg::SLOT_W-1:0]    slot,
  output logic        [lrs_pkg::USE_W-1:0]     use_count,
  output logic                                 evicted,
  output logic signed [lrs_pkg::VALUE_W-1:0]   evicted_value
);
  import lrs_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int BIT_W  = $clog2(COUNT_WIDTH);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic signed [VALUE_W-1:0]     values [DEPTH];
  logic        [COUNT_WIDTH-1:0] counts [DEPTH];
  logic signed [VALUE_W-1:0]     item;
  logic        [DEPTH-1:0]       match_vec;
  logic        [DEPTH-1:0]       cand;
  logic        [BIT_W-1:0]       bitpos;
  logic        [FILL_W-1:0]      fill;
  logic        [CAP_W-1:0]       cap;

  logic [CMP_W-1:0]       eff_cap;
  logic [CMP_W-1:0]       fill_clamp;
  logic [DEPTH-1:0]       valid_c;
  logic [DEPTH-1:0]       valid_r;
  logic [DEPTH-1:0]       match_c;
  logic [DEPTH-1:0]       zeros;
  logic [DEPTH-1:0]       hit_oh;
  logic [DEPTH-1:0]       low_oh;
  logic [DEPTH-1:0]       low_le;
  logic [IDX_W-1:0]       hit_idx;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic [VALUE_W-1:0]     ev_sel;

  always_comb begin
    if (CMP_W'(cap) == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap);
    end
    fill_clamp = (CMP_W'(fill) > eff_cap) ? eff_cap : CMP_W'(fill);
  end

  // Each cell compares against the incoming value in parallel.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_c[i] = CMP_W'(i) < fill_clamp;
      valid_r[i] = CMP_W'(i) < CMP_W'(fill);
      match_c[i] = valid_c[i] && (values[i] == in_item);
      zeros[i]   = cand[i] && !counts[i][bitpos];
    end
  end

  assign hit_oh = match_vec & (~match_vec + DEPTH'(1));
  assign low_oh = cand & (~cand + DEPTH'(1));
  assign low_le = low_oh | (low_oh - DEPTH'(1));

  always_comb begin
    hit_idx = '0;
    cnt_sel = '0;
    ev_sel  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_oh[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        cnt_sel = cnt_sel | counts[i];
      end
      if (low_oh[i]) begin
        ev_sel = ev_sel | values[i];
      end
    end
    inc_val = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_WIDTH'(1);
  end

  assign status.hit_any  = |match_vec;
  assign status.full     = CMP_W'(fill) >= eff_cap;
  assign status.bit_last = (bitpos == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cap  <= CAP_RESET;
    end else begin
      if (cfg_wr) begin
        cap <= cfg_data;
      end
      if (cmd.load) begin
        fill <= FILL_W'(fill_clamp);
      end else if (cmd.commit_insert) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item      <= in_item;
      match_vec <= match_c;
    end
    if (cmd.mask_init) begin
      cand   <= valid_r;
      bitpos <= BIT_W'(COUNT_WIDTH - 1);
    end
    if (cmd.mask_step) begin
      if (|zeros) begin
        cand <= zeros;
      end
      bitpos <= bitpos - BIT_W'(1);
    end
    if (cmd.commit_hit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (hit_oh[i]) begin
          counts[i] <= inc_val;
        end
      end
      hit           <= 1'b1;
      slot          <= SLOT_W'(hit_idx);
      use_count     <= USE_W'(inc_val);
      evicted       <= 1'b0;
      evicted_value <= '0;
    end
    if (cmd.commit_insert || cmd.commit_evict) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (cmd.commit_insert || low_le[i]) begin
          values[i] <= values[i-1];
          counts[i] <= counts[i-1];
        end
      end
      values[0]     <= item;
      counts[0]     <= COUNT_WIDTH'(1);
      hit           <= 1'b0;
      slot          <= '0;
      use_count     <= USE_W'(1);
      evicted       <= cmd.commit_evict;
      evicted_value <= cmd.commit_evict ? ev_sel : '0;
    end
  end

  // Stored values are unique, so a hit names exactly one cell.
  a_hit_single: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_hit |-> $onehot(match_vec))
    else $error("hit on more than one entry");

  // The minimum search never loses all of its candidates.
  a_cand_live: assert property (@(posedge clk) disable iff (rst)
    cmd.mask_step |-> (|cand))
    else $error("minimum search has no candidate");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill count beyond built depth");

endmodule
